### rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mse_pkg.sv
// Package with the shared types and constants of the merge sort engine.
package mse_pkg;

    localparam int DATA_W            = 32;
    localparam int MAX_ITEMS_DEFAULT = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // Phases of the engine: collecting words, then draining them in order.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } mse_state_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic  occ;
        logic  lt;
        data_t data;
    } cell_link_t;

    // Virtual neighbor left of the first cell: always full, never smaller.
    localparam cell_link_t LINK_HEAD = '{occ: 1'b1, lt: 1'b0, data: '0};
    // Virtual neighbor right of the last cell: always empty.
    localparam cell_link_t LINK_TAIL = '{occ: 1'b0, lt: 1'b0, data: '0};

endpackage

### rtl/mse_in_if.sv
// Input channel: one list element per word, with an end-of-list mark.
interface mse_in_if
    import mse_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

### rtl/mse_out_if.sv
// Output channel: one sorted element per word, with a final-element mark.
interface mse_out_if
    import mse_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t sorted_value;
    logic  last_res;

    modport source (output valid, output sorted_value, output last_res, input ready);
    modport sink   (input valid, input sorted_value, input last_res, output ready);
endinterface

### rtl/merge_sort_engine.sv
// Sorter: words enter one per cycle while loading into a sorted chain of cells and then drain in order.
// Load: one word per cycle; each word that fits is placed in sorted order in the same cycle.
// The first sorted word is offered in the cycle after the word marked last is taken,
// then one word per cycle while the sink is ready.
// Input is held off while a list drains.
// Reset (rst_n, asynchronous, active low) empties the chain and returns to loading.
`include "assert_macros.svh"

module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
    input logic        clk,
    input logic        rst_n,
    mse_in_if.sink     item,
    mse_out_if.source  result
);

    cell_ctrl_t ctrl;
    cell_link_t links [MAX_ITEMS];
    logic       out_last;

    // The final word is out when the second cell is empty.
    assign out_last = !links[1].occ;

    mse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_last   (item.last),
        .out_ready (result.ready),
        .out_last  (out_last),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .ctrl      (ctrl)
    );

    // Row of cells, smallest element at the head.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        cell_link_t left_link;
        cell_link_t right_link;

        if (i == 0)
        begin : g_head
            assign left_link = LINK_HEAD;
        end
        else
        begin : g_mid_l
            assign left_link = links[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign right_link = LINK_TAIL;
        end
        else
        begin : g_mid_r
            assign right_link = links[i+1];
        end

        mse_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_value (item.value),
            .left      (left_link),
            .right     (right_link),
            .link      (links[i])
        );
    end

    assign result.sorted_value = links[0].data;
    assign result.last_res     = out_last;

    // Checks on the sequencing and the chain.
    `ASSERT_IMPLIES(a_phase_excl, clk, rst_n, 1'b1, !(item.ready && result.valid), "load and drain overlap")
    `ASSERT_NEXT(a_last_starts_drain, clk, rst_n, item.valid && item.ready && item.last, result.valid, "no drain after last word")
    `ASSERT_IMPLIES(a_drain_has_word, clk, rst_n, result.valid, links[0].occ, "drain from empty chain")
    `ASSERT_NEXT(a_end_empties, clk, rst_n, result.valid && result.ready && result.last_res, item.ready && !links[0].occ, "chain not empty after drain")

endmodule

### rtl/mse_cell.sv
// One cell of the insertion chain: holds a single element and its occupied flag.
module mse_cell
    import mse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  data_t      new_value,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t link
);

    logic  occ_reg;
    logic  occ_next;
    data_t data_reg;
    data_t data_next;
    logic  lt;

    // The new word belongs in front of this cell's element.
    assign lt = occ_reg && (new_value < data_reg);

    assign link.occ  = occ_reg;
    assign link.lt   = lt;
    assign link.data = data_reg;

    // Insert: take the left neighbor's element when it moves over, or take the
    // new word at the first place where it fits. Drain: pull from the right.
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (ctrl.shift_out)
        begin
            occ_next  = right.occ;
            data_next = right.data;
        end
        else if (ctrl.insert)
        begin
            if (left.lt)
            begin
                occ_next  = left.occ;
                data_next = left.data;
            end
            else if ((lt || !occ_reg) && left.occ)
            begin
                occ_next  = 1'b1;
                data_next = new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### rtl/mse_ctrl.sv
// Controller: load/drain sequencing and the element count.
module mse_ctrl
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    input  logic       out_ready,
    input  logic       out_last,
    output logic       in_ready,
    output logic       out_valid,
    output cell_ctrl_t ctrl
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    mse_state_t       state_reg;
    mse_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;
    logic             room;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign room    = count_reg < CNT_W'(MAX_ITEMS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_acc && out_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs of the sequencer. Ready is always high while loading and valid is
    // always high while draining, so the handshakes reduce to the other side.
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        ctrl.insert    = 1'b0;
        ctrl.shift_out = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready    = 1'b1;
                ctrl.insert = in_valid && room;
            end
            ST_DRAIN:
            begin
                out_valid      = 1'b1;
                ctrl.shift_out = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Element count; words past the capacity are dropped.
    always_comb
    begin
        count_next = count_reg;
        if (out_acc && out_last)
        begin
            count_next = '0;
        end
        else if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

### verif/merge_sort_engine_tb.sv
// Testbench that sends lists to the merge sort engine and checks each sorted word it returns.
`timescale 1ns / 1ps

module merge_sort_engine_tb
    import mse_pkg::*;
();

    localparam int CAPACITY  = MAX_ITEMS_DEFAULT;
    localparam int TAIL_WAIT = 16;

    // Tracks the list being loaded and the sorted words still owed by the engine.
    class sort_scoreboard;
        data_t open_list[$];
        data_t owed_value[$];
        logic  owed_last[$];
        int    errors = 0;

        function void report(string what, data_t exp_v, logic exp_l, data_t got_v, logic got_l);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected %0d last %0b, got %0d last %0b",
                         $realtime, what, exp_v, exp_l, got_v, got_l);
        endfunction

        // Words past the store capacity are dropped; the last mark still closes the list.
        function void note_word(data_t v, logic l);
            data_t ordered[$];
            int    pos;
            if (open_list.size() < CAPACITY)
                open_list.push_back(v);
            if (!l)
                return;
            // Equal words cannot be told apart, so a plain insertion keeps the order exact.
            foreach (open_list[i])
            begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] <= open_list[i])
                    pos++;
                ordered.insert(pos, open_list[i]);
            end
            foreach (ordered[i])
            begin
                owed_value.push_back(ordered[i]);
                owed_last.push_back(i == ordered.size() - 1);
            end
            open_list.delete();
        endfunction

        function void check_word(data_t v, logic l);
            data_t exp_v;
            logic  exp_l;
            if (owed_value.size() == 0)
            begin
                report("word with none expected", '0, 1'b0, v, l);
                return;
            end
            exp_v = owed_value.pop_front();
            exp_l = owed_last.pop_front();
            if (v !== exp_v || l !== exp_l)
                report("sorted word mismatch", exp_v, exp_l, v, l);
        endfunction

        function int pending();
            return owed_value.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   sent_words;

    mse_in_if  item_ch();
    mse_out_if result_ch();

    sort_scoreboard sb = new();

    merge_sort_engine #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Output side: ready drops at random according to the current stall rate.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Results are taken at the edge after this half cycle; the signals are settled here.
    always @(negedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_word(result_ch.sorted_value, result_ch.last_res);
    end

    // Mixes full-range words, a narrow band that yields duplicates, and the extremes.
    function automatic data_t pick_value();
        case ($urandom_range(3))
            0: return data_t'(int'($urandom_range(8)) - 4);
            1:
            begin
                case ($urandom_range(3))
                    0: return data_t'(32'h8000_0000);
                    1: return data_t'(32'h7fff_ffff);
                    2: return data_t'(-1);
                    default: return data_t'(0);
                endcase
            end
            default: return data_t'($urandom);
        endcase
    endfunction

    // Offers one word, with random idle cycles first, and returns at the edge that takes it.
    task automatic send_word(data_t v, logic l);
        logic took;
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.last  <= l;
        do
        begin
            @(negedge clk);
            took = item_ch.ready;
            @(posedge clk);
        end while (took !== 1'b1);
        sb.note_word(v, l);
        sent_words++;
    endtask

    task automatic send_list(data_t words[$]);
        foreach (words[i])
            send_word(words[i], i == words.size() - 1);
    endtask

    task automatic send_random_list(int len);
        data_t words[$];
        repeat (len)
            words.push_back(pick_value());
        send_list(words);
    endtask

    // Holds the input low until every owed word has come back.
    task automatic drain_all();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Main sequence: reset, directed lists, then random lists under each idling mix.
    initial
    begin
        int phase_start;
        int pick;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.value   = '0;
        item_ch.last    = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        sent_words      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single word, extremes, reversed order, duplicates, already sorted.
        send_list('{data_t'(5)});
        send_list('{data_t'(32'h7fff_ffff), data_t'(32'h8000_0000), data_t'(0),
                    data_t'(-1), data_t'(1)});
        send_list('{data_t'(40), data_t'(30), data_t'(20), data_t'(10), data_t'(-10)});
        send_list('{data_t'(3), data_t'(3), data_t'(-3), data_t'(3), data_t'(-3)});
        send_list('{data_t'(-7), data_t'(0), data_t'(7), data_t'(32'h7fff_ffff)});

        // Store exactly full, then overfilled with the last mark on a dropped word.
        send_random_list(CAPACITY);
        send_random_list(CAPACITY + 2);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            phase_start = sent_words;
            while (sent_words - phase_start < 24)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    send_random_list($urandom_range(CAPACITY - 1, CAPACITY + 2));
                else if (pick < 20)
                    send_random_list(1);
                else
                    send_random_list($urandom_range(2, 12));
            end
            // Let the sender sit idle until the engine has returned everything.
            if (phase == 1)
                drain_all();
        end

        drain_all();
        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a stuck handshake.
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
